### rtl/core/sit_pkg.sv
// Shared types, constants and address helper for the sorted integer set table.
package sit_pkg;

    localparam int CAPACITY    = 64;
    localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int DATA_W      = 32;
    localparam int COUNT_OUT_W = 7;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_APPEND = 2'd1,
        MODE_QUERY  = 2'd2,
        MODE_POP    = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_DUP   = 2'd1,
        STATUS_FULL  = 2'd2,
        STATUS_EMPTY = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_TAIL,
        ST_HEAD,
        ST_ISCAN,
        ST_PLACE,
        ST_SHIFT,
        ST_WRITE,
        ST_QSCAN,
        ST_POP,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic             load;
        logic             rd_en;
        logic [CNT_W-1:0] rd_lidx;
        logic             wr_en;
        logic [CNT_W-1:0] wr_lidx;
        logic             wr_from_value;
        logic             status_we;
        status_t          status_code;
        logic             found_set;
        logic             pop_take;
        logic             count_inc;
    } sit_cmd_t;

    typedef struct packed {
        mode_t            mode;
        logic [CNT_W-1:0] count;
        logic             full;
        logic             nodup;
        logic             eq;
        logic             lt;
    } sit_sts_t;

    // Maps a position in list order to a physical slot of the circular store.
    function automatic logic [IDX_W-1:0] phys_addr(input logic [IDX_W-1:0] head,
                                                   input logic [CNT_W-1:0] lidx);
        logic [CNT_W:0] sum;
        sum = (CNT_W + 1)'(head) + (CNT_W + 1)'(lidx);
        if (sum >= (CNT_W + 1)'(CAPACITY))
            sum = sum - (CNT_W + 1)'(CAPACITY);
        return sum[IDX_W-1:0];
    endfunction

endpackage

### rtl/core/sit_ctrl.sv
// Sequencer for the sorted set table: scans, shifts and result timing.
module sit_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  sit_pkg::sit_sts_t sts,
    output sit_pkg::sit_cmd_t cmd,
    output logic              busy,
    output logic              done
);

    sit_pkg::state_t state_reg, state_next;
    logic [sit_pkg::CNT_W-1:0] idx_reg, idx_next;
    logic [sit_pkg::CNT_W-1:0] pos_reg, pos_next;

    logic [sit_pkg::CNT_W-1:0] last_idx;
    logic                      at_last;
    logic                      dup_hit;

    assign last_idx = sts.count - sit_pkg::CNT_W'(1);
    assign at_last  = (idx_reg == last_idx);
    assign dup_hit  = sts.nodup && sts.eq;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sit_pkg::ST_IDLE;
            idx_reg   <= '0;
            pos_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            pos_reg   <= pos_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        pos_next   = pos_reg;
        case (state_reg)
            sit_pkg::ST_IDLE:
            begin
                if (start)
                    state_next = sit_pkg::ST_DECODE;
            end
            sit_pkg::ST_DECODE:
            begin
                case (sts.mode)
                    sit_pkg::MODE_INSERT:
                    begin
                        if (sts.count == '0)
                        begin
                            pos_next   = '0;
                            state_next = sit_pkg::ST_PLACE;
                        end
                        else
                            state_next = sit_pkg::ST_TAIL;
                    end
                    sit_pkg::MODE_APPEND:
                    begin
                        pos_next   = sts.count;
                        state_next = sit_pkg::ST_PLACE;
                    end
                    sit_pkg::MODE_QUERY:
                    begin
                        idx_next   = '0;
                        state_next = (sts.count == '0) ? sit_pkg::ST_FINISH : sit_pkg::ST_QSCAN;
                    end
                    default:
                    begin
                        state_next = (sts.count == '0) ? sit_pkg::ST_FINISH : sit_pkg::ST_POP;
                    end
                endcase
            end
            sit_pkg::ST_TAIL:
            begin
                if (dup_hit)
                    state_next = sit_pkg::ST_FINISH;
                else if (!sts.lt)
                begin
                    pos_next   = sts.count;
                    state_next = sit_pkg::ST_PLACE;
                end
                else
                    state_next = sit_pkg::ST_HEAD;
            end
            sit_pkg::ST_HEAD:
            begin
                if (dup_hit)
                    state_next = sit_pkg::ST_FINISH;
                else if (sts.lt)
                begin
                    pos_next   = '0;
                    state_next = sit_pkg::ST_PLACE;
                end
                else
                begin
                    idx_next   = sit_pkg::CNT_W'(1);
                    state_next = sit_pkg::ST_ISCAN;
                end
            end
            sit_pkg::ST_ISCAN:
            begin
                // The tail is larger than the value, so the last entry always ends the scan.
                if (dup_hit)
                    state_next = sit_pkg::ST_FINISH;
                else if (sts.lt || at_last)
                begin
                    pos_next   = idx_reg;
                    state_next = sit_pkg::ST_PLACE;
                end
                else
                    idx_next = idx_reg + sit_pkg::CNT_W'(1);
            end
            sit_pkg::ST_PLACE:
            begin
                if (sts.full)
                    state_next = sit_pkg::ST_FINISH;
                else if (pos_reg == sts.count)
                    state_next = sit_pkg::ST_WRITE;
                else
                begin
                    idx_next   = sts.count;
                    state_next = sit_pkg::ST_SHIFT;
                end
            end
            sit_pkg::ST_SHIFT:
            begin
                if ((idx_reg - sit_pkg::CNT_W'(1)) == pos_reg)
                    state_next = sit_pkg::ST_WRITE;
                else
                    idx_next = idx_reg - sit_pkg::CNT_W'(1);
            end
            sit_pkg::ST_WRITE:
            begin
                state_next = sit_pkg::ST_FINISH;
            end
            sit_pkg::ST_QSCAN:
            begin
                if (sts.eq || at_last)
                    state_next = sit_pkg::ST_FINISH;
                else
                    idx_next = idx_reg + sit_pkg::CNT_W'(1);
            end
            sit_pkg::ST_POP:
            begin
                state_next = sit_pkg::ST_FINISH;
            end
            sit_pkg::ST_FINISH:
            begin
                state_next = sit_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = sit_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd             = '0;
        cmd.status_code = sit_pkg::STATUS_DONE;
        busy            = (state_reg != sit_pkg::ST_IDLE);
        done            = (state_reg == sit_pkg::ST_FINISH);
        case (state_reg)
            sit_pkg::ST_IDLE:
            begin
                cmd.load = start;
            end
            sit_pkg::ST_DECODE:
            begin
                if (sts.count != '0)
                begin
                    if (sts.mode == sit_pkg::MODE_INSERT)
                    begin
                        cmd.rd_en   = 1'b1;
                        cmd.rd_lidx = last_idx;
                    end
                    else if ((sts.mode == sit_pkg::MODE_QUERY) || (sts.mode == sit_pkg::MODE_POP))
                    begin
                        cmd.rd_en   = 1'b1;
                        cmd.rd_lidx = '0;
                    end
                end
                else if (sts.mode == sit_pkg::MODE_POP)
                begin
                    cmd.status_we   = 1'b1;
                    cmd.status_code = sit_pkg::STATUS_EMPTY;
                end
            end
            sit_pkg::ST_TAIL:
            begin
                if (dup_hit)
                begin
                    cmd.status_we   = 1'b1;
                    cmd.status_code = sit_pkg::STATUS_DUP;
                end
                else if (sts.lt)
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_lidx = '0;
                end
            end
            sit_pkg::ST_HEAD:
            begin
                if (dup_hit)
                begin
                    cmd.status_we   = 1'b1;
                    cmd.status_code = sit_pkg::STATUS_DUP;
                end
                else if (!sts.lt)
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_lidx = sit_pkg::CNT_W'(1);
                end
            end
            sit_pkg::ST_ISCAN:
            begin
                if (dup_hit)
                begin
                    cmd.status_we   = 1'b1;
                    cmd.status_code = sit_pkg::STATUS_DUP;
                end
                else if (!(sts.lt || at_last))
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_lidx = idx_reg + sit_pkg::CNT_W'(1);
                end
            end
            sit_pkg::ST_PLACE:
            begin
                if (sts.full)
                begin
                    cmd.status_we   = 1'b1;
                    cmd.status_code = sit_pkg::STATUS_FULL;
                end
                else if (pos_reg != sts.count)
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_lidx = last_idx;
                end
            end
            sit_pkg::ST_SHIFT:
            begin
                // Each cycle moves one entry up while the next one is being read.
                cmd.wr_en   = 1'b1;
                cmd.wr_lidx = idx_reg;
                if ((idx_reg - sit_pkg::CNT_W'(1)) != pos_reg)
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_lidx = idx_reg - sit_pkg::CNT_W'(2);
                end
            end
            sit_pkg::ST_WRITE:
            begin
                cmd.wr_en         = 1'b1;
                cmd.wr_lidx       = pos_reg;
                cmd.wr_from_value = 1'b1;
                cmd.count_inc     = 1'b1;
            end
            sit_pkg::ST_QSCAN:
            begin
                if (sts.eq)
                    cmd.found_set = 1'b1;
                else if (!at_last)
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_lidx = idx_reg + sit_pkg::CNT_W'(1);
                end
            end
            sit_pkg::ST_POP:
            begin
                cmd.pop_take = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

### rtl/core/sit_datapath.sv
// Entry store, head pointer, count, compare logic and result registers.
module sit_datapath (
    input  logic                       clk,
    input  logic                       rst_n,
    input  sit_pkg::sit_cmd_t          cmd,
    input  logic [1:0]                 mode,
    input  logic signed [31:0]         value,
    input  logic                       cfg_we,
    input  logic                       cfg_wdata,
    output sit_pkg::sit_sts_t          sts,
    output logic [1:0]                 status,
    output logic                       found,
    output logic signed [31:0]         popped_value,
    output logic [sit_pkg::COUNT_OUT_W-1:0] count
);

    logic [sit_pkg::DATA_W-1:0] mem [sit_pkg::CAPACITY];
    logic [sit_pkg::DATA_W-1:0] rd_data_reg;

    logic [sit_pkg::IDX_W-1:0]  head_reg, head_next;
    logic [sit_pkg::CNT_W-1:0]  count_reg, count_next;
    logic                       allow_dup_reg;

    sit_pkg::mode_t             mode_reg;
    logic [sit_pkg::DATA_W-1:0] value_reg;
    sit_pkg::status_t           status_reg;
    logic                       found_reg;
    logic [sit_pkg::DATA_W-1:0] popped_reg;

    logic [sit_pkg::IDX_W-1:0]  rd_addr;
    logic [sit_pkg::IDX_W-1:0]  wr_addr;
    logic [sit_pkg::DATA_W-1:0] wr_data;

    assign rd_addr = sit_pkg::phys_addr(head_reg, cmd.rd_lidx);
    assign wr_addr = sit_pkg::phys_addr(head_reg, cmd.wr_lidx);
    assign wr_data = cmd.wr_from_value ? value_reg : rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
            mem[wr_addr] <= wr_data;
        if (cmd.rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        if (cmd.pop_take)
        begin
            head_next  = (head_reg == sit_pkg::IDX_W'(sit_pkg::CAPACITY - 1)) ?
                         '0 : head_reg + sit_pkg::IDX_W'(1);
            count_next = count_reg - sit_pkg::CNT_W'(1);
        end
        else if (cmd.count_inc)
            count_next = count_reg + sit_pkg::CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            count_reg     <= '0;
            allow_dup_reg <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
            if (cfg_we)
                allow_dup_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg   <= sit_pkg::mode_t'(mode);
            value_reg  <= value;
            status_reg <= sit_pkg::STATUS_DONE;
            found_reg  <= 1'b0;
            popped_reg <= '0;
        end
        else
        begin
            if (cmd.status_we)
                status_reg <= cmd.status_code;
            if (cmd.found_set)
                found_reg <= 1'b1;
            if (cmd.pop_take)
                popped_reg <= rd_data_reg;
        end
    end

    always_comb
    begin
        sts.mode  = mode_reg;
        sts.count = count_reg;
        sts.full  = (count_reg >= sit_pkg::CNT_W'(sit_pkg::CAPACITY));
        sts.nodup = !allow_dup_reg;
        sts.eq    = (rd_data_reg == value_reg);
        sts.lt    = ($signed(value_reg) < $signed(rd_data_reg));
    end

    assign status       = status_reg;
    assign found        = found_reg;
    assign popped_value = popped_reg;
    assign count        = sit_pkg::COUNT_OUT_W'(count_reg);

endmodule

### rtl/core/sorted_int_set_table.sv
// Top level of the sorted integer set table: controller plus datapath.
//
//  Channel   Signals                                   Handshake
//  request   start, mode, value                        start && !busy
//  result    done, status, found, popped_value, count  done, one cycle
//  config    cfg_we, cfg_wdata (allow_duplicates)      cfg_we
//
// Entries sit in a circular store with one read and one write port, read one entry per
// cycle, so the time a request takes grows with the number of entries it touches.
// Reset clears the count, head pointer and allow_duplicates; the store is not cleared.
// busy stays high from acceptance through the done cycle; results cannot be stalled.
module sorted_int_set_table (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [1:0]                 mode,
    input  logic signed [31:0]         value,
    input  logic                       cfg_we,
    input  logic                       cfg_wdata,
    output logic                       done,
    output logic [1:0]                 status,
    output logic                       found,
    output logic signed [31:0]         popped_value,
    output logic [sit_pkg::COUNT_OUT_W-1:0] count
);

    sit_pkg::sit_cmd_t cmd;
    sit_pkg::sit_sts_t sts;

    sit_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    sit_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .mode         (mode),
        .value        (value),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .sts          (sts),
        .status       (status),
        .found        (found),
        .popped_value (popped_value),
        .count        (count)
    );

endmodule

### rtl/core/sit_checker.sv
// Port-level checks for the sorted integer set table, bound to the top level.
module sit_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       start,
    input logic                       busy,
    input logic                       done,
    input logic [1:0]                 status,
    input logic                       found,
    input logic [sit_pkg::COUNT_OUT_W-1:0] count
);

    // A result beat lasts exactly one cycle.
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held longer than one cycle");

    // An accepted request makes the block busy at once.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    // The block only goes idle right after delivering a result.
    a_idle_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> $past(done))
        else $error("busy dropped without a result");

    // The count does not move while nothing is in flight.
    a_count_stable_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (!busy && !start) |=> $stable(count))
        else $error("count changed while idle");

    // A pop on an empty store reports zero entries, and a hit is a plain success.
    a_result_codes: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((status != sit_pkg::STATUS_EMPTY) || (count == '0))
              && (!found || (status == sit_pkg::STATUS_DONE)))
        else $error("inconsistent result fields");

endmodule

bind sorted_int_set_table sit_checker u_sit_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .status (status),
    .found  (found),
    .count  (count)
);

### test/tb_sorted_int_set_table.sv
`timescale 1ns / 100ps
// Testbench for sorted_int_set_table: random and directed requests, every result checked.
module tb_sorted_int_set_table;

    localparam int HALF_PERIOD = 4;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SETTLE_CYCLES = 200;
    localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] INT_MAX = 32'sh7fff_ffff;

    typedef struct {
        sit_pkg::status_t                  status;
        logic                              found;
        logic signed [31:0]                popped;
        logic [sit_pkg::COUNT_OUT_W-1:0]   count;
    } set_reply_t;

    // Tracks the contents of the set and the reply each accepted request must produce.
    class int_set_scoreboard;
        set_reply_t         replies_due[$];
        logic signed [31:0] held[sit_pkg::CAPACITY];
        int                 held_count;
        bit                 keep_equal;
        int                 errors;

        function int pending();
            return replies_due.size();
        endfunction

        function void set_keep_equal(bit keep);
            keep_equal = keep;
        endfunction

        function void place(int pos, logic signed [31:0] v);
            int k;
            for (k = held_count; k > pos; k--)
                held[k] = held[k - 1];
            held[pos] = v;
            held_count++;
        endfunction

        function sit_pkg::status_t sorted_insert(logic signed [31:0] v);
            int  pos;
            int  k;
            bit  nodup;
            nodup = !keep_equal;
            pos = 0;
            if (held_count > 0)
            begin
                if (nodup && held[held_count - 1] == v)
                    return sit_pkg::STATUS_DUP;
                if (v >= held[held_count - 1])
                    pos = held_count;
                else if (nodup && held[0] == v)
                    return sit_pkg::STATUS_DUP;
                else if (v < held[0])
                    pos = 0;
                else
                begin
                    // The tail is larger than v, so the scan always stops.
                    pos = held_count - 1;
                    for (k = 1; k < held_count; k++)
                    begin
                        if (nodup && held[k] == v)
                            return sit_pkg::STATUS_DUP;
                        if (v < held[k])
                        begin
                            pos = k;
                            break;
                        end
                    end
                end
            end
            if (held_count >= sit_pkg::CAPACITY)
                return sit_pkg::STATUS_FULL;
            place(pos, v);
            return sit_pkg::STATUS_DONE;
        endfunction

        function void note_request(sit_pkg::mode_t m, logic signed [31:0] v);
            set_reply_t r;
            int         k;
            r.status = sit_pkg::STATUS_DONE;
            r.found  = 1'b0;
            r.popped = '0;
            case (m)
                sit_pkg::MODE_INSERT: r.status = sorted_insert(v);
                sit_pkg::MODE_APPEND:
                begin
                    if (held_count >= sit_pkg::CAPACITY)
                        r.status = sit_pkg::STATUS_FULL;
                    else
                        place(held_count, v);
                end
                sit_pkg::MODE_QUERY:
                begin
                    for (k = 0; k < held_count; k++)
                        if (held[k] == v)
                            r.found = 1'b1;
                end
                default:
                begin
                    if (held_count == 0)
                        r.status = sit_pkg::STATUS_EMPTY;
                    else
                    begin
                        r.popped = held[0];
                        for (k = 1; k < held_count; k++)
                            held[k - 1] = held[k];
                        held_count--;
                    end
                end
            endcase
            r.count = sit_pkg::COUNT_OUT_W'(held_count);
            replies_due.push_back(r);
        endfunction

        function void check_result(logic [1:0] st, logic fnd, logic signed [31:0] pv,
                                   logic [sit_pkg::COUNT_OUT_W-1:0] cnt);
            set_reply_t r;
            if (replies_due.size() == 0)
            begin
                $display("%0t: result beat with nothing pending: expected none, actual status %0d",
                         $time, st);
                errors++;
                return;
            end
            r = replies_due.pop_front();
            if (st !== r.status)
            begin
                $display("%0t: status expected %0d actual %0d", $time, r.status, st);
                errors++;
            end
            if (fnd !== r.found)
            begin
                $display("%0t: found expected %0d actual %0d", $time, r.found, fnd);
                errors++;
            end
            if (pv !== r.popped)
            begin
                $display("%0t: popped_value expected %0d actual %0d", $time, r.popped, pv);
                errors++;
            end
            if (cnt !== r.count)
            begin
                $display("%0t: count expected %0d actual %0d", $time, r.count, cnt);
                errors++;
            end
        endfunction
    endclass

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            start;
    logic                            busy;
    sit_pkg::mode_t                  mode;
    logic signed [31:0]              value;
    logic                            cfg_we;
    logic                            cfg_wdata;
    logic                            done;
    logic [1:0]                      status;
    logic                            found;
    logic signed [31:0]              popped_value;
    logic [sit_pkg::COUNT_OUT_W-1:0] count;

    int_set_scoreboard sb;
    int                cycles = 0;

    sorted_int_set_table dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .mode         (mode),
        .value        (value),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .done         (done),
        .status       (status),
        .found        (found),
        .popped_value (popped_value),
        .count        (count)
    );

    always #HALF_PERIOD clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("sorted_int_set_table test failed");
            $finish;
        end
    end

    // Outputs are read before this edge's updates land, so each beat is seen once.
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(status, found, popped_value, count);
    end

    task automatic send(input sit_pkg::mode_t m, input logic signed [31:0] v);
        start <= 1'b1;
        mode  <= m;
        value <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_request(m, v);
    endtask

    // Holds start low through one cycle in which the block could have taken a beat.
    task automatic skip_ready_cycle();
        start <= 1'b0;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // The register may only change once every outstanding result has come back.
    task automatic write_keep_equal(input bit keep);
        start <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= keep;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_keep_equal(keep);
    endtask

    function automatic logic signed [31:0] pick_value();
        logic signed [31:0] v;
        case ($urandom_range(0, 9))
            0, 1: v = $urandom;
            2: v = $urandom_range(0, 1) ? INT_MAX : INT_MIN;
            default:
            begin
                // A narrow pool keeps equal values and hits common.
                v = $urandom_range(0, 80);
                v = v - 40;
            end
        endcase
        return v;
    endfunction

    task automatic run_phase(input int items, input int pct_ins, input int pct_app,
                             input int pct_qry, input bit gaps);
        int             n;
        int             pick;
        sit_pkg::mode_t m;
        for (n = 0; n < items; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < pct_ins)
                m = sit_pkg::MODE_INSERT;
            else if (pick < pct_ins + pct_app)
                m = sit_pkg::MODE_APPEND;
            else if (pick < pct_ins + pct_app + pct_qry)
                m = sit_pkg::MODE_QUERY;
            else
                m = sit_pkg::MODE_POP;
            send(m, pick_value());
            if (gaps)
                while ($urandom_range(0, 99) < 33)
                    skip_ready_cycle();
        end
    endtask

    initial
    begin
        logic signed [31:0] last_tail;
        sb = new();
        rst_n     <= 1'b0;
        start     <= 1'b0;
        mode      <= sit_pkg::MODE_INSERT;
        value     <= '0;
        cfg_we    <= 1'b0;
        cfg_wdata <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_keep_equal(1'b0);
        send(sit_pkg::MODE_POP, 32'sd9);
        send(sit_pkg::MODE_QUERY, 32'sd5);
        send(sit_pkg::MODE_INSERT, 32'sd0);
        send(sit_pkg::MODE_INSERT, 32'sd0);
        send(sit_pkg::MODE_INSERT, INT_MAX);
        send(sit_pkg::MODE_INSERT, INT_MIN);
        send(sit_pkg::MODE_INSERT, INT_MIN);
        send(sit_pkg::MODE_INSERT, 32'sd7);
        send(sit_pkg::MODE_INSERT, 32'sd7);
        send(sit_pkg::MODE_INSERT, -32'sd1);
        send(sit_pkg::MODE_QUERY, 32'sd7);
        send(sit_pkg::MODE_QUERY, 32'sd8);
        send(sit_pkg::MODE_QUERY, INT_MAX);
        // Appending below the tail breaks the order; later inserts must still follow it.
        send(sit_pkg::MODE_APPEND, 32'sd3);
        send(sit_pkg::MODE_INSERT, 32'sd3);
        send(sit_pkg::MODE_INSERT, 32'sd5);
        send(sit_pkg::MODE_INSERT, 32'sd1);
        send(sit_pkg::MODE_INSERT, -32'sd1);
        send(sit_pkg::MODE_APPEND, INT_MIN);
        send(sit_pkg::MODE_INSERT, INT_MIN);
        send(sit_pkg::MODE_POP, 32'sd0);
        send(sit_pkg::MODE_QUERY, INT_MIN);

        // Fill the store, then probe the full cases in both register settings.
        last_tail = '0;
        while (sb.held_count < sit_pkg::CAPACITY)
        begin
            last_tail = $urandom;
            send(sit_pkg::MODE_APPEND, last_tail);
        end
        send(sit_pkg::MODE_APPEND, $urandom);
        send(sit_pkg::MODE_INSERT, last_tail);
        send(sit_pkg::MODE_INSERT, 32'sh0000_1234);
        write_keep_equal(1'b1);
        send(sit_pkg::MODE_INSERT, last_tail);

        run_phase(80, 10, 5, 15, 1'b1);
        write_keep_equal(1'b0);
        run_phase(140, 65, 10, 15, 1'b1);
        write_keep_equal(1'b1);
        run_phase(150, 35, 15, 20, 1'b0);
        write_keep_equal(1'b0);
        run_phase(120, 15, 5, 20, 1'b1);
        write_keep_equal(1'b1);
        run_phase(150, 65, 10, 10, 1'b1);
        write_keep_equal(1'b0);
        run_phase(150, 35, 15, 20, 1'b1);

        start <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("sorted_int_set_table test passed");
        else
            $display("sorted_int_set_table test failed");
        $finish;
    end
endmodule
